// ===== sv/alpha_stamp_blender_top_assert.svh =====
// Assertion macros for the stamp blender top level.
// Expects signals clk and rst in the scope where the macros are used.
`ifndef ALPHA_STAMP_BLENDER_TOP_ASSERT_SVH
`define ALPHA_STAMP_BLENDER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/asb_pkg.sv =====
// Shared types and constants for the alpha stamp blender.
// No dependencies; imported by the mixer, the top level and the testbench.
package asb_pkg;

  localparam int MAX_STAMP_W_DEF = 64;
  localparam int MAX_STAMP_H_DEF = 64;
  localparam int COORD_BITS_DEF  = 12;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STAMP_W  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STAMP_H  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOOL_X   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOOL_Y   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_W = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_H = 3'd6;

  // Operation carried on func with each input transfer.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_BLEND = 1'b1
  } func_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // Request handed from the address stage to the mixer.
  typedef struct packed {
    logic  hit;
    rgba_t pix;
  } blend_req_t;

  // Finished pixel leaving the mixer.
  typedef struct packed {
    logic  blended;
    rgba_t pix;
  } blend_res_t;

endpackage

// ===== sv/asb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module asb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AB-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AB-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/asb_mix.sv =====
// Blend stage: per-channel weighted sum, registered, then rounded divide by 255.
// Depends on asb_pkg.
module asb_mix (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_vld,
  input  asb_pkg::blend_req_t req,
  input  asb_pkg::rgba_t     texel,
  output logic               res_vld,
  output asb_pkg::blend_res_t res
);
  import asb_pkg::*;

  function automatic logic [15:0] mix_sum(input logic [7:0] bg, input logic [7:0] st,
                                          input logic [7:0] a);
    logic [15:0] keep;
    logic [15:0] add;
    keep = 16'(bg) * 16'(8'd255 - a);
    add  = 16'(st) * 16'(a);
    return keep + add;
  endfunction

  // Rounded divide by 255 for sums up to 255*255; reciprocal by shift and add.
  function automatic logic [7:0] div255(input logic [15:0] sum);
    logic [15:0] y;
    logic [15:0] t;
    y = sum + 16'd127;
    t = y + {8'd0, y[15:8]} + 16'd1;
    return t[15:8];
  endfunction

  logic [7:0]  a;
  rgba_t       st;
  logic        s2_vld;
  logic        s2_hit;
  logic [7:0]  s2_alpha;
  logic [15:0] s2_red;
  logic [15:0] s2_green;
  logic [15:0] s2_blue;

  // A pixel outside the window mixes with zero weight, which returns it unchanged.
  assign a  = req.hit ? texel.alpha : 8'd0;
  assign st = req.hit ? texel : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_hit   <= req.hit;
    s2_alpha <= req.pix.alpha;
    s2_red   <= mix_sum(req.pix.red, st.red, a);
    s2_green <= mix_sum(req.pix.green, st.green, a);
    s2_blue  <= mix_sum(req.pix.blue, st.blue, a);
  end

  assign res_vld         = s2_vld;
  assign res.blended     = s2_hit;
  assign res.pix.red     = div255(s2_red);
  assign res.pix.green   = div255(s2_green);
  assign res.pix.blue    = div255(s2_blue);
  assign res.pix.alpha   = s2_alpha;

endmodule

// ===== sv/alpha_stamp_blender_top.sv =====
// Top level of the alpha stamp blender: config registers, window test, stamp
// store, mixer and output queue. Depends on asb_pkg, asb_ram, asb_mix and the assertion header.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------------
//   input    | in        | in_valid / in_stall   | func pos_x pos_y in_red..in_alpha
//   output   | out       | out_valid / out_stall | out_red..out_alpha blended
//   config   | in        | cfg_valid / cfg_ready | cfg_index cfg_data
//
// One item per cycle while in_stall is low. A blend pixel passes through the stamp store read,
// the weighted sum, then the divide into a four-entry output queue.
// in_stall rises when four blend pixels are outstanding, set by the queue depth.
// In-range loads write the stamp store in their transfer cycle and return nothing.
// Reset restores the register defaults and empties the pipeline; stamp store
// contents are undefined until loaded. cfg_ready is always high.
`include "alpha_stamp_blender_top_assert.svh"

module alpha_stamp_blender_top #(
  parameter int MAX_STAMP_W = asb_pkg::MAX_STAMP_W_DEF,
  parameter int MAX_STAMP_H = asb_pkg::MAX_STAMP_H_DEF,
  parameter int COORD_BITS  = asb_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [COORD_BITS-1:0]             pos_x,
  input  logic [COORD_BITS-1:0]             pos_y,
  input  logic [7:0]                        in_red,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_blue,
  input  logic [7:0]                        in_alpha,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic [7:0]                        out_alpha,
  output logic                              blended,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [asb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [asb_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import asb_pkg::*;

  localparam int DEPTH      = MAX_STAMP_W * MAX_STAMP_H;
  localparam int AB         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XB         = (MAX_STAMP_W > 1) ? $clog2(MAX_STAMP_W) : 1;
  localparam int YB         = (MAX_STAMP_H > 1) ? $clog2(MAX_STAMP_H) : 1;
  localparam int CW         = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = 2;
  localparam int CNT_BITS   = 3;

  // Configuration registers.
  logic        enable;
  logic [6:0]  stamp_width;
  logic [6:0]  stamp_height;
  logic [11:0] tool_x;
  logic [11:0] tool_y;
  logic [12:0] canvas_width;
  logic [12:0] canvas_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      stamp_width   <= 7'd64;
      stamp_height  <= 7'd64;
      tool_x        <= 12'd0;
      tool_y        <= 12'd0;
      canvas_width  <= 13'd4096;
      canvas_height <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:   enable        <= cfg_data[0];
        REG_STAMP_W:  stamp_width   <= cfg_data[6:0];
        REG_STAMP_H:  stamp_height  <= cfg_data[6:0];
        REG_TOOL_X:   tool_x        <= cfg_data[11:0];
        REG_TOOL_Y:   tool_y        <= cfg_data[11:0];
        REG_CANVAS_W: canvas_width  <= cfg_data;
        REG_CANVAS_H: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window test. Since coordinates are never negative, the clamp of the lower
  // edge at zero drops out, and the upper clamp becomes a separate canvas test.
  logic [6:0]    sw;
  logic [6:0]    sh;
  logic [CW-1:0] px_e;
  logic [CW-1:0] py_e;
  logic [CW-1:0] tx_e;
  logic [CW-1:0] ty_e;
  logic [CW-1:0] hx_e;
  logic [CW-1:0] hy_e;
  logic [CW-1:0] sx_full;
  logic [CW-1:0] sy_full;
  logic          in_x;
  logic          in_y;
  logic          hit;

  assign sw   = (stamp_width > MAX_STAMP_W) ? 7'(MAX_STAMP_W) : stamp_width;
  assign sh   = (stamp_height > MAX_STAMP_H) ? 7'(MAX_STAMP_H) : stamp_height;
  assign px_e = CW'(pos_x);
  assign py_e = CW'(pos_y);
  assign tx_e = CW'(tool_x);
  assign ty_e = CW'(tool_y);
  assign hx_e = CW'(sw[6:1]);
  assign hy_e = CW'(sh[6:1]);

  assign in_x = (px_e + hx_e >= tx_e) && (px_e < tx_e + hx_e) &&
                (px_e + CW'(1) < CW'(canvas_width));
  assign in_y = (py_e + hy_e >= ty_e) && (py_e < ty_e + hy_e) &&
                (py_e + CW'(1) < CW'(canvas_height));
  assign hit  = enable && in_x && in_y;

  // Inside the window the offset stays below the clipped stamp size.
  assign sx_full = px_e + hx_e - tx_e;
  assign sy_full = py_e + hy_e - ty_e;

  logic          in_acc;
  logic          blend_acc;
  logic          ld_ok;
  logic          we;
  logic [AB-1:0] waddr;
  logic [AB-1:0] raddr;
  rgba_t         in_pix;
  rgba_t         texel;

  assign in_acc    = in_valid && !in_stall;
  assign blend_acc = in_acc && (func == OP_BLEND);
  assign ld_ok     = (pos_x < MAX_STAMP_W) && (pos_y < MAX_STAMP_H);
  assign we        = in_acc && (func == OP_LOAD) && ld_ok;
  assign waddr     = AB'(pos_y[YB-1:0]) * AB'(MAX_STAMP_W) + AB'(pos_x[XB-1:0]);
  assign raddr     = AB'(sy_full[YB-1:0]) * AB'(MAX_STAMP_W) + AB'(sx_full[XB-1:0]);

  assign in_pix.red   = in_red;
  assign in_pix.green = in_green;
  assign in_pix.blue  = in_blue;
  assign in_pix.alpha = in_alpha;

  asb_ram #(
    .WIDTH ($bits(rgba_t)),
    .DEPTH (DEPTH),
    .AB    (AB)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_pix),
    .re    (blend_acc),
    .raddr (raddr),
    .rdata (texel)
  );

  // Read stage: the request waits here while the stamp store returns the texel.
  logic       s1_vld;
  blend_req_t s1_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= blend_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (blend_acc) begin
      s1_req.hit <= hit;
      s1_req.pix <= in_pix;
    end
  end

  logic       res_vld;
  blend_res_t res;

  asb_mix u_mix (
    .clk     (clk),
    .rst     (rst),
    .req_vld (s1_vld),
    .req     (s1_req),
    .texel   (texel),
    .res_vld (res_vld),
    .res     (res)
  );

  // Output queue. The outstanding count covers pixels still in the pipeline,
  // so the queue can never overflow and in_stall does not depend combinationally on out_stall.
  blend_res_t          fifo [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wptr;
  logic [PTR_BITS-1:0] rptr;
  logic [CNT_BITS-1:0] fifo_cnt;
  logic [CNT_BITS-1:0] pending;
  logic                pop;
  blend_res_t          head;

  assign out_valid = fifo_cnt != '0;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = pending == CNT_BITS'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr     <= '0;
      rptr     <= '0;
      fifo_cnt <= '0;
      pending  <= '0;
    end else begin
      if (res_vld) begin
        wptr <= wptr + PTR_BITS'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_BITS'(1);
      end
      fifo_cnt <= fifo_cnt + CNT_BITS'(res_vld) - CNT_BITS'(pop);
      pending  <= pending + CNT_BITS'(blend_acc) - CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      fifo[wptr] <= res;
    end
  end

  assign head      = fifo[rptr];
  assign out_red   = head.pix.red;
  assign out_green = head.pix.green;
  assign out_blue  = head.pix.blue;
  assign out_alpha = head.pix.alpha;
  assign blended   = head.blended;

  `ASB_ASSERT_IMP(a_queue_within_pending, 1'b1, fifo_cnt <= pending, "queue holds more than outstanding")
  `ASB_ASSERT_IMP(a_out_needs_pending, out_valid, pending != '0, "output shown with nothing outstanding")
  `ASB_ASSERT_NXT(a_blend_enters_read, blend_acc, s1_vld, "accepted blend did not reach read stage")
  `ASB_ASSERT_NXT(a_pending_drops, pop && !blend_acc, pending == $past(pending) - 3'd1, "outstanding count did not drop")

endmodule

// ===== dv/alpha_stamp_blender_top_tb.sv =====
// Self-checking testbench for alpha_stamp_blender_top: stamp loads, windowed blends, register setups.
// Carries its own stamp store and window math to predict every output pixel not given a fixed golden value.
// Depends on asb_pkg and the blender RTL only.
`timescale 1ns / 1ps

module alpha_stamp_blender_top_tb;
  import asb_pkg::*;

  localparam int STAMP_W_MAX  = MAX_STAMP_W_DEF;
  localparam int STAMP_H_MAX  = MAX_STAMP_H_DEF;
  localparam int RESET_CYCLES = 7;
  localparam int ITEM_TARGET  = 800;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRESS_SETUP  = 2;

  typedef struct {
    bit         is_reg;
    logic [2:0] reg_idx;
    logic [12:0] reg_val;
    func_t      op;
    int         x;
    int         y;
    logic [31:0] rgba;
    bit         typed;
    blend_res_t golden;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [11:0] pos_x = '0;
  logic [11:0] pos_y = '0;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic [7:0]  in_alpha = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        blended;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predictor state: register copies and the stamp store.
  int          cur_en = 0;
  int          cur_sw = 64;
  int          cur_sh = 64;
  int          cur_tx = 0;
  int          cur_ty = 0;
  int          cur_cw = 4096;
  int          cur_ch = 4096;
  logic [31:0] stamp_mem [0:STAMP_W_MAX*STAMP_H_MAX-1];
  bit          texel_set [0:STAMP_W_MAX*STAMP_H_MAX-1];

  blend_res_t  pending_pixels[$];
  blend_res_t  head;
  plan_row_t   plan[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          in_gap_pct = 0;
  int          out_idle_rate = 0;
  int          hold_left = 0;
  bit          pressure_req = 1'b0;
  bit          pressure_seen = 1'b0;

  alpha_stamp_blender_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha),
    .blended   (blended),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int eff_w();
    return (cur_sw > STAMP_W_MAX) ? STAMP_W_MAX : cur_sw;
  endfunction

  function automatic int eff_h();
    return (cur_sh > STAMP_H_MAX) ? STAMP_H_MAX : cur_sh;
  endfunction

  function automatic int axis_lo(int centre, int size);
    int v;
    v = centre - size / 2;
    return (v < 0) ? 0 : v;
  endfunction

  // Upper bound is exclusive and clipped one short of the canvas edge.
  function automatic int axis_hi(int centre, int size, int extent);
    int v;
    v = centre + size / 2;
    return (v > extent - 1) ? extent - 1 : v;
  endfunction

  function automatic bit window_hit(int x, int y);
    return cur_en != 0 &&
           x >= axis_lo(cur_tx, eff_w()) && x < axis_hi(cur_tx, eff_w(), cur_cw) &&
           y >= axis_lo(cur_ty, eff_h()) && y < axis_hi(cur_ty, eff_h(), cur_ch);
  endfunction

  function automatic int texel_index(int x, int y);
    return (y - (cur_ty - eff_h() / 2)) * STAMP_W_MAX + (x - (cur_tx - eff_w() / 2));
  endfunction

  function automatic logic [7:0] mix8(int base, int ink, int a);
    return 8'((base * (255 - a) + ink * a + 127) / 255);
  endfunction

  function automatic blend_res_t predict_blend(int x, int y, logic [31:0] rgba);
    blend_res_t  res;
    logic [31:0] t;
    res.pix     = rgba;
    res.blended = window_hit(x, y);
    if (res.blended) begin
      t = stamp_mem[texel_index(x, y)];
      res.pix.red   = mix8(rgba[31:24], t[31:24], t[7:0]);
      res.pix.green = mix8(rgba[23:16], t[23:16], t[7:0]);
      res.pix.blue  = mix8(rgba[15:8], t[15:8], t[7:0]);
    end
    return res;
  endfunction

  function automatic logic [31:0] random_texel();
    logic [7:0] a;
    case ($urandom_range(0, 3))
      0: a = 8'h00;
      1: a = 8'hff;
      default: a = $urandom_range(0, 255);
    endcase
    return {24'($urandom), a};
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 64;
      2: return $urandom_range(65, 127);
      3: return 1;
      4: return 2;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic int pick_extent();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4096;
      2: return $urandom_range(4097, 8191);
      3: return 1;
      4, 5: return $urandom_range(2, 100);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic int pick_centre(int extent);
    int lim;
    lim = (extent == 0 || extent > 4096) ? 4096 : extent;
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      2: return lim - 1;
      default: return $urandom_range(0, lim - 1);
    endcase
  endfunction

  // Coordinate around the window, one step past each side so the edges get hit.
  function automatic int pick_near(int lo, int hi);
    int a;
    int b;
    a = (lo - 1 < 0) ? 0 : lo - 1;
    b = (hi > 4095) ? 4095 : hi;
    if (b < a) return a;
    return $urandom_range(b, a);
  endfunction

  function automatic void plan_reg(logic [2:0] idx, logic [12:0] val);
    plan_row_t row;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.op      = OP_LOAD;
    row.x       = 0;
    row.y       = 0;
    row.rgba    = '0;
    row.typed   = 1'b0;
    row.golden  = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_px(func_t op, int x, int y, logic [31:0] rgba,
                                  bit typed, logic [32:0] golden);
    plan_row_t row;
    row.is_reg  = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.op      = op;
    row.x       = x;
    row.y       = y;
    row.rgba    = rgba;
    row.typed   = typed;
    row.golden  = golden;
    plan.push_back(row);
  endfunction

  // Drops valid and waits until every pixel is back, then idles before returning.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE:   cur_en = val[0];
      REG_STAMP_W:  cur_sw = val[6:0];
      REG_STAMP_H:  cur_sh = val[6:0];
      REG_TOOL_X:   cur_tx = val[11:0];
      REG_TOOL_Y:   cur_ty = val[11:0];
      REG_CANVAS_W: cur_cw = val;
      REG_CANVAS_H: cur_ch = val;
      default: ;
    endcase
  endtask

  // Offers one item and returns at the edge where it is transferred, valid still high.
  task automatic push_item(func_t op, int x, int y, logic [31:0] rgba,
                           bit typed, blend_res_t golden);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    pos_x    <= x[11:0];
    pos_y    <= y[11:0];
    in_red   <= rgba[31:24];
    in_green <= rgba[23:16];
    in_blue  <= rgba[15:8];
    in_alpha <= rgba[7:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD) begin
      if (x < STAMP_W_MAX && y < STAMP_H_MAX) begin
        stamp_mem[y * STAMP_W_MAX + x] = rgba;
        texel_set[y * STAMP_W_MAX + x] = 1'b1;
      end
    end else begin
      pending_pixels.push_back(typed ? golden : predict_blend(x, y, rgba));
    end
  endtask

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: output transfer with no pixel expected: expected none, actual %0h",
                 $time, {blended, out_red, out_green, out_blue, out_alpha});
        fail_count++;
      end else begin
        head = pending_pixels.pop_front();
        check_field("red", head.pix.red, out_red);
        check_field("green", head.pix.green, out_green);
        check_field("blue", head.pix.blue, out_blue);
        check_field("alpha", head.pix.alpha, out_alpha);
        check_field("blended", 8'(head.blended), 8'(blended));
      end
    end
  end

  // Output back-pressure: random bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall     <= 1'b0;
      hold_left     <= 0;
      pressure_seen <= 1'b0;
    end else if (pressure_req && !pressure_seen) begin
      pressure_seen <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      out_stall     <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else if (hold_left == 1) begin
      hold_left <= 0;
      out_stall <= 1'b0;
    end else if (out_idle_rate != 0 && $urandom_range(0, 99) < out_idle_rate) begin
      hold_left <= $urandom_range(1, 18);
      out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int          counted;
    int          setup_no;
    int          n;
    int          k;
    int          x;
    int          y;
    int          idx;
    int          cw;
    int          ch;
    logic [31:0] rgba;

    counted  = 0;
    setup_no = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Stamping is off after reset, so pixels pass untouched.
    plan_px(OP_BLEND, 0, 0, 32'hff00ff80, 1, {1'b0, 32'hff00ff80});
    plan_px(OP_BLEND, 4095, 4095, 32'h00ff00ff, 1, {1'b0, 32'h00ff00ff});
    plan_px(OP_LOAD, 0, 0, 32'hffffffff, 0, '0);
    plan_px(OP_LOAD, 63, 63, 32'ha5a5a500, 0, '0);
    plan_px(OP_LOAD, 32, 32, 32'h80402080, 0, '0);
    // Out-of-range loads; a truncated address would land on texels read below.
    plan_px(OP_LOAD, 64, 63, 32'h12345678, 0, '0);
    plan_px(OP_LOAD, 0, 64, 32'h9abcdef0, 0, '0);
    plan_px(OP_LOAD, 4095, 4095, 32'h0f0f0f0f, 0, '0);
    plan_reg(REG_ENABLE, 13'd1);
    plan_reg(REG_TOOL_X, 13'd32);
    plan_reg(REG_TOOL_Y, 13'd32);
    plan_px(OP_BLEND, 0, 0, 32'h00000055, 1, {1'b1, 32'hffffff55});
    plan_px(OP_BLEND, 63, 63, 32'h1234569a, 1, {1'b1, 32'h1234569a});
    plan_px(OP_BLEND, 64, 0, 32'h11223344, 1, {1'b0, 32'h11223344});
    plan_px(OP_BLEND, 0, 64, 32'h55667788, 1, {1'b0, 32'h55667788});
    plan_px(OP_BLEND, 32, 32, 32'hc0c0c0c0, 0, '0);
    // Window clipped at the origin.
    plan_reg(REG_TOOL_X, 13'd0);
    plan_reg(REG_TOOL_Y, 13'd0);
    plan_px(OP_BLEND, 0, 0, 32'h3c5a7801, 0, '0);
    plan_px(OP_BLEND, 31, 31, 32'h01020304, 1, {1'b1, 32'h01020304});
    plan_px(OP_BLEND, 32, 0, 32'h0a0b0c0d, 1, {1'b0, 32'h0a0b0c0d});
    // Window clipped at the far canvas corner.
    plan_reg(REG_TOOL_X, 13'd4095);
    plan_reg(REG_TOOL_Y, 13'd4095);
    plan_px(OP_BLEND, 4063, 4063, 32'h00000000, 1, {1'b1, 32'hffffff00});
    plan_px(OP_BLEND, 4095, 4095, 32'hffffffff, 1, {1'b0, 32'hffffffff});
    // Oversize stamp saturates to the store size.
    plan_reg(REG_TOOL_X, 13'd32);
    plan_reg(REG_TOOL_Y, 13'd32);
    plan_reg(REG_STAMP_W, 13'd127);
    plan_reg(REG_STAMP_H, 13'd100);
    plan_px(OP_BLEND, 63, 63, 32'h7f7f7f7f, 1, {1'b1, 32'h7f7f7f7f});
    // Empty windows: zero stamp width, zero canvas width, single-row canvas.
    plan_reg(REG_STAMP_W, 13'd0);
    plan_px(OP_BLEND, 32, 32, 32'h10203040, 1, {1'b0, 32'h10203040});
    plan_reg(REG_STAMP_W, 13'd64);
    plan_reg(REG_CANVAS_W, 13'd0);
    plan_px(OP_BLEND, 0, 0, 32'h50607080, 1, {1'b0, 32'h50607080});
    plan_reg(REG_CANVAS_W, 13'd8191);
    plan_reg(REG_CANVAS_H, 13'd1);
    plan_px(OP_BLEND, 5, 0, 32'h01010101, 1, {1'b0, 32'h01010101});
    plan_reg(REG_CANVAS_H, 13'd4096);
    plan_reg(REG_ENABLE, 13'd0);
    plan_px(OP_BLEND, 32, 32, 32'h89abcdef, 1, {1'b0, 32'h89abcdef});

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_item(plan[i].op, plan[i].x, plan[i].y, plan[i].rgba, plan[i].typed,
                  plan[i].golden);
      end
    end

    while (counted < ITEM_TARGET) begin
      setup_no++;
      cw = pick_extent();
      ch = pick_extent();
      write_reg(REG_ENABLE, 13'($urandom_range(0, 9) != 0));
      write_reg(REG_STAMP_W, 13'(pick_size()));
      write_reg(REG_STAMP_H, 13'(pick_size()));
      write_reg(REG_TOOL_X, 13'(pick_centre(cw)));
      write_reg(REG_TOOL_Y, 13'(pick_centre(ch)));
      write_reg(REG_CANVAS_W, 13'(cw));
      write_reg(REG_CANVAS_H, 13'(ch));
      if (counted >= ITEM_TARGET - 120) begin
        in_gap_pct    = 0;
        out_idle_rate <= 0;
      end else begin
        in_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 25);
        out_idle_rate <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 20);
      end
      if (setup_no == PRESS_SETUP) begin
        // Keep offering pixels while the output is held off, so the queue fills.
        in_gap_pct = 0;
        pressure_req <= 1'b1;
      end
      n = $urandom_range(40, 90);
      for (k = 0; k < n; k++) begin
        if (setup_no != PRESS_SETUP && $urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 4) == 0) begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
          end else begin
            x = $urandom_range(0, STAMP_W_MAX - 1);
            y = $urandom_range(0, STAMP_H_MAX - 1);
          end
          push_item(OP_LOAD, x, y, random_texel(), 0, '0);
          if (x < STAMP_W_MAX && y < STAMP_H_MAX) counted++;
        end else begin
          if ($urandom_range(0, 9) < 8) begin
            x = pick_near(axis_lo(cur_tx, eff_w()), axis_hi(cur_tx, eff_w(), cur_cw));
            y = pick_near(axis_lo(cur_ty, eff_h()), axis_hi(cur_ty, eff_h(), cur_ch));
          end else begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
          end
          // A blend never reads a texel that was not loaded first.
          if (window_hit(x, y)) begin
            idx = texel_index(x, y);
            if (!texel_set[idx]) begin
              push_item(OP_LOAD, idx % STAMP_W_MAX, idx / STAMP_W_MAX, random_texel(), 0, '0);
              counted++;
            end
          end
          rgba = $urandom;
          push_item(OP_BLEND, x, y, rgba, 0, '0);
          counted++;
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== alpha_stamp_blender_top.f =====
+incdir+sv
sv/asb_pkg.sv
sv/asb_ram.sv
sv/asb_mix.sv
sv/alpha_stamp_blender_top.sv
dv/alpha_stamp_blender_top_tb.sv
